### sv/fdsc_pkg.sv
// Shared types and constants for the frame decoder with sum check.
// Holds the parser state enum, the controller command and status
// structs, and the frame layout constants. No dependencies.
`default_nettype none

package fdsc_pkg;

   // Frame start pattern
   localparam logic [7:0] SYNC_A_BYTE = 8'hB1;
   localparam logic [7:0] SYNC_B_BYTE = 8'h75;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int ID_W    = 16;
   localparam int LEN_W   = 6;
   localparam int LIMIT_W = 7;

   // Largest payload the 6-bit length field can describe, plus one
   localparam int LEN_CAP = 64;

   // Reset value of the payload limit register
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   // Packed result width: id, channel, length, byte, padded to bytes
   localparam int RSP_FIELDS_W = ID_W + BYTE_W + LEN_W + BYTE_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [3:0] {
      ST_SYNC_A,
      ST_SYNC_B,
      ST_ID_HI,
      ST_ID_LO,
      ST_CHAN,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_DATA,
      ST_CHK_A,
      ST_CHK_B,
      ST_FETCH,
      ST_SEND,
      ST_EMPTY
   } fdsc_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic sum_clear;   // zero both sums before any add this cycle
      logic sum_add;     // add the input byte into the running sums
      logic load_id_hi;
      logic load_id_lo;
      logic load_chan;
      logic load_len_hi;
      logic load_len_lo; // also restarts the payload byte count
      logic store_byte;  // write the input byte into the payload store
      logic load_check;
      logic idx_clear;   // restart readout at the first payload byte
      logic idx_inc;     // step readout to the next payload byte
      logic rd_en;       // read the store at the readout index
      logic out_has;     // result carries a payload byte
   } fdsc_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_sync_a;
      logic is_sync_b;
      logic chan_ok;
      logic len_ok;
      logic len_zero;
      logic data_done;
      logic check_ok;
      logic held_len_zero;
      logic read_last;
   } fdsc_status_type;

endpackage

`default_nettype wire

### sv/fdsc_datapath.sv
// Datapath of the frame decoder: header registers, running sums,
// payload store, readout index and limit register.
// Depends on fdsc_pkg; driven by commands from fdsc_ctrl.
`default_nettype none

module fdsc_datapath
   import fdsc_pkg::*;
#(
   parameter int STORE_DEPTH   = 64,
   parameter int CHANNEL_COUNT = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [BYTE_W-1:0]      rx_byte,
   input  wire logic                   csr_write_en,
   input  wire logic [LIMIT_W-1:0]     csr_write_data,
   input  wire fdsc_cmd_type           cmd,
   output fdsc_status_type             status,
   output logic      [RSP_DATA_W-1:0]  rsp_data
);

   localparam int ADDR_W    = $clog2(STORE_DEPTH);
   localparam int DEPTH_CAP = (STORE_DEPTH < LEN_CAP) ? STORE_DEPTH : LEN_CAP;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [BYTE_W-1:0]  sum_first_ff, sum_first_in;
   logic [BYTE_W-1:0]  sum_second_ff, sum_second_in;
   logic [ID_W-1:0]    id_ff;
   logic [BYTE_W-1:0]  chan_ff;
   logic [BYTE_W-1:0]  len_hi_ff;
   logic [LEN_W-1:0]   len_ff;
   logic [BYTE_W-1:0]  check_ff;
   logic [LEN_W-1:0]   rx_count_ff, rx_count_in;
   logic [LEN_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [BYTE_W-1:0]  rd_data_ff;
   logic [BYTE_W-1:0]  store_mem [STORE_DEPTH];

   logic [LIMIT_W-1:0] limit_eff;
   logic [BYTE_W-1:0]  sum_first_base;
   logic [BYTE_W-1:0]  sum_second_base;
   logic [LEN_W:0]     rx_count_next;
   logic [LEN_W:0]     rd_idx_next;
   logic [BYTE_W-1:0]  out_byte;

   // Effective length limit: least of the register, the store depth and LEN_CAP
   assign limit_eff = (limit_ff > LIMIT_W'(DEPTH_CAP)) ? LIMIT_W'(DEPTH_CAP) : limit_ff;

   assign rx_count_next = {1'b0, rx_count_ff} + 1'b1;
   assign rd_idx_next   = {1'b0, rd_idx_ff} + 1'b1;

   // Status toward the controller
   always_comb begin
      status.is_sync_a     = (rx_byte == SYNC_A_BYTE);
      status.is_sync_b     = (rx_byte == SYNC_B_BYTE);
      status.chan_ok       = (rx_byte < BYTE_W'(CHANNEL_COUNT));
      status.len_ok        = (len_hi_ff == '0) && (rx_byte < {1'b0, limit_eff});
      status.len_zero      = (rx_byte == '0);
      status.data_done     = (rx_count_next >= {1'b0, len_ff});
      status.check_ok      = (check_ff == sum_first_ff) && (rx_byte == sum_second_ff);
      status.held_len_zero = (len_ff == '0);
      status.read_last     = (rd_idx_next == {1'b0, len_ff});
   end

   // Running sums: optional clear, then first += byte, second += first
   always_comb begin
      sum_first_base  = cmd.sum_clear ? '0 : sum_first_ff;
      sum_second_base = cmd.sum_clear ? '0 : sum_second_ff;
      sum_first_in    = sum_first_base;
      sum_second_in   = sum_second_base;
      if (cmd.sum_add) begin
         sum_first_in  = sum_first_base + rx_byte;
         sum_second_in = sum_second_base + sum_first_in;
      end
   end

   // Counters and limit register next values
   always_comb begin
      limit_in    = csr_write_en ? csr_write_data : limit_ff;
      rx_count_in = rx_count_ff;
      if (cmd.load_len_lo) begin
         rx_count_in = '0;
      end else if (cmd.store_byte) begin
         rx_count_in = rx_count_next[LEN_W-1:0];
      end
      rd_idx_in = rd_idx_ff;
      if (cmd.idx_clear) begin
         rd_idx_in = '0;
      end else if (cmd.idx_inc) begin
         rd_idx_in = rd_idx_next[LEN_W-1:0];
      end
   end

   // Control-side registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         sum_first_ff  <= '0;
         sum_second_ff <= '0;
         rx_count_ff   <= '0;
         rd_idx_ff     <= '0;
      end else begin
         limit_ff      <= limit_in;
         sum_first_ff  <= sum_first_in;
         sum_second_ff <= sum_second_in;
         rx_count_ff   <= rx_count_in;
         rd_idx_ff     <= rd_idx_in;
      end
   end

   // Header and check byte capture
   always_ff @(posedge clock) begin
      if (cmd.load_id_hi) begin
         id_ff <= {{(ID_W-BYTE_W){1'b0}}, rx_byte};
      end
      if (cmd.load_id_lo) begin
         id_ff <= {id_ff[BYTE_W-1:0], rx_byte};
      end
      if (cmd.load_chan) begin
         chan_ff <= rx_byte;
      end
      if (cmd.load_len_hi) begin
         len_hi_ff <= rx_byte;
      end
      if (cmd.load_len_lo) begin
         len_ff <= rx_byte[LEN_W-1:0];
      end
      if (cmd.load_check) begin
         check_ff <= rx_byte;
      end
   end

   // Payload store: write while receiving, registered read on readout
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         store_mem[ADDR_W'(rx_count_ff)] <= rx_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_mem[ADDR_W'(rd_idx_ff)];
      end
   end

   // Result beat: id, channel, length, byte from the lowest bit up
   assign out_byte = cmd.out_has ? rd_data_ff : '0;
   assign rsp_data = {{(RSP_DATA_W-RSP_FIELDS_W){1'b0}}, out_byte, len_ff, chan_ff, id_ff};

endmodule

`default_nettype wire

### sv/fdsc_ctrl.sv
// Controller of the frame decoder: frame parser and readout sequencer.
// Depends on fdsc_pkg; issues commands to fdsc_datapath and reads its status.
`default_nettype none

module fdsc_ctrl
   import fdsc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   output logic                 rsp_tlast,
   input  wire fdsc_status_type status,
   output fdsc_cmd_type         cmd
);

   fdsc_state_type state_ff, state_in;
   logic           accept;

   // Take bytes in every parser state, hold input during readout
   assign req_tready = (state_ff <= ST_CHK_B);
   assign accept     = req_tvalid & req_tready;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC_A;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state; a dropped frame retries the byte as a first start byte
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_SYNC_A: begin
            if (accept && status.is_sync_a) state_in = ST_SYNC_B;
         end
         ST_SYNC_B: begin
            if (accept) begin
               if (status.is_sync_b) state_in = ST_ID_HI;
               else state_in = status.is_sync_a ? ST_SYNC_B : ST_SYNC_A;
            end
         end
         ST_ID_HI: begin
            if (accept) state_in = ST_ID_LO;
         end
         ST_ID_LO: begin
            if (accept) state_in = ST_CHAN;
         end
         ST_CHAN: begin
            if (accept) begin
               if (status.chan_ok) state_in = ST_LEN_HI;
               else state_in = status.is_sync_a ? ST_SYNC_B : ST_SYNC_A;
            end
         end
         ST_LEN_HI: begin
            if (accept) state_in = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            if (accept) begin
               if (status.len_ok) state_in = status.len_zero ? ST_CHK_A : ST_DATA;
               else state_in = status.is_sync_a ? ST_SYNC_B : ST_SYNC_A;
            end
         end
         ST_DATA: begin
            if (accept && status.data_done) state_in = ST_CHK_A;
         end
         ST_CHK_A: begin
            if (accept) state_in = ST_CHK_B;
         end
         ST_CHK_B: begin
            if (accept) begin
               if (status.check_ok) state_in = status.held_len_zero ? ST_EMPTY : ST_FETCH;
               else state_in = status.is_sync_a ? ST_SYNC_B : ST_SYNC_A;
            end
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) state_in = status.read_last ? ST_SYNC_A : ST_FETCH;
         end
         ST_EMPTY: begin
            if (rsp_tready) state_in = ST_SYNC_A;
         end
         default: begin
            state_in = ST_SYNC_A;
         end
      endcase
   end

   // Outputs and datapath commands
   always_comb begin
      cmd        = '0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = 1'b0;
      case (state_ff)
         ST_SYNC_A: begin
            cmd.sum_add = accept & status.is_sync_a;
         end
         ST_SYNC_B: begin
            if (accept) begin
               if (status.is_sync_b) begin
                  cmd.sum_add = 1'b1;
               end else begin
                  cmd.sum_clear = 1'b1;
                  cmd.sum_add   = status.is_sync_a;
               end
            end
         end
         ST_ID_HI: begin
            cmd.load_id_hi = accept;
            cmd.sum_add    = accept;
         end
         ST_ID_LO: begin
            cmd.load_id_lo = accept;
            cmd.sum_add    = accept;
         end
         ST_CHAN: begin
            cmd.load_chan = accept;
            if (accept) begin
               if (status.chan_ok) begin
                  cmd.sum_add = 1'b1;
               end else begin
                  cmd.sum_clear = 1'b1;
                  cmd.sum_add   = status.is_sync_a;
               end
            end
         end
         ST_LEN_HI: begin
            cmd.load_len_hi = accept;
            cmd.sum_add     = accept;
         end
         ST_LEN_LO: begin
            if (accept) begin
               if (status.len_ok) begin
                  cmd.load_len_lo = 1'b1;
                  cmd.sum_add     = 1'b1;
               end else begin
                  cmd.sum_clear = 1'b1;
                  cmd.sum_add   = status.is_sync_a;
               end
            end
         end
         ST_DATA: begin
            cmd.store_byte = accept;
            cmd.sum_add    = accept;
         end
         ST_CHK_A: begin
            cmd.load_check = accept;
         end
         ST_CHK_B: begin
            if (accept) begin
               cmd.sum_clear = 1'b1;
               if (status.check_ok) begin
                  cmd.idx_clear = 1'b1;
               end else begin
                  cmd.sum_add = status.is_sync_a;
               end
            end
         end
         ST_FETCH: begin
            cmd.rd_en = 1'b1;
         end
         ST_SEND: begin
            rsp_tvalid  = 1'b1;
            rsp_tlast   = status.read_last;
            cmd.out_has = 1'b1;
            cmd.idx_inc = rsp_tready & ~status.read_last;
         end
         ST_EMPTY: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/frame_decoder_with_sum_check.sv
// Frame decoder with sum check, top level.
// Instantiates fdsc_ctrl and fdsc_datapath; depends on fdsc_pkg.
//
// Usage:
//   req_* takes one received byte per beat. Frames are B1 75, id (2 bytes),
//   channel, length (2 bytes), payload, two check bytes. Running mod-256
//   sums over all bytes before the check bytes must match the check bytes.
//   Frames with a bad channel, a length not below the limit, or a bad check
//   are dropped and the offending byte is retried as a first start byte.
//   rsp_* delivers one beat per payload byte of a good frame (rsp_tuser=1),
//   or one empty beat (rsp_tuser=0) for a zero-length frame; rsp_tlast
//   marks the final beat. csr_* writes the payload length limit (reset 64).
// Data flow:
//   Input bytes are taken back to back while the parser runs. After the
//   final check byte, each payload beat is first read from the store and
//   then presented, as set by the single registered read port of the
//   payload store; input is not taken while a frame is being read out.
// Reset clears the parser to waiting for a start byte, and the limit to 64.
// A stalled receiver holds the current result beat and the parser waits.
`default_nettype none

module frame_decoder_with_sum_check
   import fdsc_pkg::*;
#(
   parameter int STORE_DEPTH   = 64,
   parameter int CHANNEL_COUNT = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Input bytes
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [BYTE_W-1:0]     req_tdata,   // [7:0] rx_byte
   // Results
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [15:0] frame_id, [23:16] frame_channel,
                                                   // [29:24] payload_length,
                                                   // [37:30] payload_byte, rest zero
   output logic                       rsp_tuser,   // [0] has_byte
   output logic                       rsp_tlast,   // last
   // Configuration
   input  wire logic                  csr_write_en,
   input  wire logic [LIMIT_W-1:0]    csr_write_data // payload_limit
);

   fdsc_cmd_type    cmd;
   fdsc_status_type status;

   assign rsp_tuser = cmd.out_has;

   fdsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   fdsc_datapath #(
      .STORE_DEPTH   (STORE_DEPTH),
      .CHANNEL_COUNT (CHANNEL_COUNT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .rx_byte        (req_tdata),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status         (status),
      .rsp_data       (rsp_tdata)
   );

endmodule

`default_nettype wire
